>>> src/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
// Depends on nothing; every other file of the block imports it.
package cbc_pkg;

    // Controller kinds held in the configuration register
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MBC1 = 2'd1,
        KIND_MBC3 = 2'd2,
        KIND_MBC5 = 2'd3
    } cart_kind_t;

    localparam int unsigned ADDR_W       = 16;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned ROM_BANK_W   = 9;
    localparam int unsigned FIXED_BANK_W = 7;
    localparam int unsigned RAM_BANK_W   = 4;
    localparam int unsigned RTC_SEL_W    = 4;

    localparam logic [3:0]        RAM_GATE_KEY  = 4'hA;
    localparam logic [DATA_W-1:0] MBC3_BANK_MAX = 8'h07;
    localparam logic [DATA_W-1:0] MBC3_RTC_MAX  = 8'h0C;
    localparam logic [DATA_W-1:0] LATCH_ARM     = 8'h00;
    localparam logic [DATA_W-1:0] LATCH_FIRE    = 8'h01;

    // Bank state kept between writes
    typedef struct packed {
        logic [7:0] bank_low;
        logic [2:0] bank_high;
        logic       bank_mode;
        logic [3:0] xram_sel;
        logic [3:0] rtc_reg_sel;
        logic       latch_armed;
    } bank_state_t;

    // One result item
    typedef struct packed {
        logic                    handled;
        logic                    gate_upd;
        logic                    ram_gate_on;
        logic                    timer_upd;
        logic                    set_rom_bank;
        logic [ROM_BANK_W-1:0]   rom_bank;
        logic                    bank0_upd;
        logic [FIXED_BANK_W-1:0] bank0_num;
        logic                    xram_upd;
        logic [RAM_BANK_W-1:0]   xram_num;
        logic                    rtc_snap;
        logic [RTC_SEL_W-1:0]    rtc_select;
    } result_t;

    // Start values of the bank state for a given controller kind
    function automatic bank_state_t init_state(cart_kind_t kind);
        bank_state_t s;
        s = '0;
        if (kind == KIND_MBC1 || kind == KIND_MBC3)
        begin
            s.bank_low = 8'd1;
        end
        return s;
    endfunction

endpackage

>>> src/cbc_if.sv
// Handshake channel interfaces for the cartridge bank controller.
// Depends on cbc_pkg for the field widths.
interface cbc_req_if;
    import cbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

interface cbc_rsp_if;
    import cbc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    handled;
    logic                    gate_upd;
    logic                    ram_gate_on;
    logic                    timer_upd;
    logic                    set_rom_bank;
    logic [ROM_BANK_W-1:0]   rom_bank;
    logic                    bank0_upd;
    logic [FIXED_BANK_W-1:0] bank0_num;
    logic                    xram_upd;
    logic [RAM_BANK_W-1:0]   xram_num;
    logic                    rtc_snap;
    logic [RTC_SEL_W-1:0]    rtc_select;
    modport source (
        output valid, output handled, output gate_upd, output ram_gate_on,
        output timer_upd, output set_rom_bank, output rom_bank,
        output bank0_upd, output bank0_num, output xram_upd,
        output xram_num, output rtc_snap, output rtc_select, input ready
    );
    modport sink (
        input valid, input handled, input gate_upd, input ram_gate_on,
        input timer_upd, input set_rom_bank, input rom_bank,
        input bank0_upd, input bank0_num, input xram_upd,
        input xram_num, input rtc_snap, input rtc_select, output ready
    );
endinterface

interface cbc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] cart_kind;
    modport source (output valid, output cart_kind, input ready);
    modport sink (input valid, input cart_kind, output ready);
endinterface

>>> src/cartridge_bank_controller_top.sv
// Top level of the cartridge bank controller: bank state, result register.
// Depends on cbc_pkg, the channel interfaces in cbc_if and cbc_decode.
//
// Usage:
//   req carries one CPU write (addr, wdata) per item. Each accepted item
//   yields exactly one result item on rsp, reporting the mapping updates
//   the write causes (RAM gate, ROM bank, fixed bank, RAM bank, RTC latch
//   and RTC register select).
//   cfg writes the controller kind (none, MBC1, MBC3, MBC5); a write also
//   restores the bank state to its start values. cfg is always ready and
//   should be used only while no result is pending.
// Timing:
//   The result is registered: it is valid in the cycle after the write is
//   accepted. Throughput is one item per cycle while rsp is ready; the
//   decode sits between the bank state registers and the result register.
// Reset:
//   Kind returns to none, bank state clears, no result is pending.
// Stalls:
//   While rsp is stalled the result register holds its item; req stays
//   ready when the register empties in the same cycle.
module cartridge_bank_controller_top
    import cbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cbc_req_if.sink   req,
    cbc_rsp_if.source rsp,
    cbc_cfg_if.sink   cfg
);

    cart_kind_t  kind_reg;
    bank_state_t state_reg;
    bank_state_t state_next;
    result_t     result_next;
    result_t     out_data_reg;
    logic        out_valid_reg;
    logic        req_fire;
    logic        rsp_fire;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;

    cbc_decode u_decode (
        .kind  (kind_reg),
        .cur   (state_reg),
        .addr  (req.addr),
        .wdata (req.wdata),
        .nxt   (state_next),
        .res   (result_next)
    );

    // Hold controller kind and bank state; reinitialise on a kind write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_NONE;
            state_reg <= init_state(KIND_NONE);
        end
        else if (cfg.valid)
        begin
            kind_reg  <= cart_kind_t'(cfg.cart_kind);
            state_reg <= init_state(cart_kind_t'(cfg.cart_kind));
        end
        else if (req_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid flag: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on accept
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            out_data_reg <= result_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.handled      = out_data_reg.handled;
    assign rsp.gate_upd     = out_data_reg.gate_upd;
    assign rsp.ram_gate_on  = out_data_reg.ram_gate_on;
    assign rsp.timer_upd    = out_data_reg.timer_upd;
    assign rsp.set_rom_bank = out_data_reg.set_rom_bank;
    assign rsp.rom_bank     = out_data_reg.rom_bank;
    assign rsp.bank0_upd    = out_data_reg.bank0_upd;
    assign rsp.bank0_num    = out_data_reg.bank0_num;
    assign rsp.xram_upd     = out_data_reg.xram_upd;
    assign rsp.xram_num     = out_data_reg.xram_num;
    assign rsp.rtc_snap     = out_data_reg.rtc_snap;
    assign rsp.rtc_select   = out_data_reg.rtc_select;

endmodule

>>> src/cbc_decode.sv
// Write decoder: turns one CPU write and the current bank state into the
// next bank state and the result item. Purely combinational; uses cbc_pkg.
module cbc_decode
    import cbc_pkg::*;
(
    input  cart_kind_t        kind,
    input  bank_state_t       cur,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output bank_state_t       nxt,
    output result_t           res
);

    logic [4:0] low5;
    logic [6:0] low7;
    logic       gate_on;

    // Zero ROM bank maps to one on MBC1 and MBC3
    assign low5    = (wdata[4:0] == 5'd0) ? 5'd1 : wdata[4:0];
    assign low7    = (wdata[6:0] == 7'd0) ? 7'd1 : wdata[6:0];
    assign gate_on = (wdata[3:0] == RAM_GATE_KEY);

    // Decode the write by controller kind and address window
    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (kind)
            KIND_MBC1:
            begin
                if (!addr[15])
                begin
                    res.handled = 1'b1;
                    unique case (addr[14:13])
                        2'b00:
                        begin
                            res.gate_upd    = 1'b1;
                            res.ram_gate_on = gate_on;
                        end
                        2'b01:
                        begin
                            nxt.bank_low     = {3'b000, low5};
                            res.set_rom_bank = 1'b1;
                            res.rom_bank     = (ROM_BANK_W'(cur.bank_high) << 5)
                                               | ROM_BANK_W'(low5);
                        end
                        2'b10:
                        begin
                            nxt.bank_high    = {1'b0, wdata[1:0]};
                            res.set_rom_bank = 1'b1;
                            res.rom_bank     = (ROM_BANK_W'(wdata[1:0]) << 5)
                                               | ROM_BANK_W'(cur.bank_low);
                            if (cur.bank_mode)
                            begin
                                res.bank0_upd = 1'b1;
                                res.bank0_num = {wdata[1:0], 5'd0};
                            end
                        end
                        default:
                        begin
                            nxt.bank_mode = wdata[0];
                            if (wdata[0])
                            begin
                                res.bank0_upd = 1'b1;
                                res.bank0_num = FIXED_BANK_W'(cur.bank_high) << 5;
                            end
                        end
                    endcase
                end
            end
            KIND_MBC3:
            begin
                if (!addr[15])
                begin
                    res.handled = 1'b1;
                    unique case (addr[14:13])
                        2'b00:
                        begin
                            res.gate_upd    = 1'b1;
                            res.timer_upd   = 1'b1;
                            res.ram_gate_on = gate_on;
                        end
                        2'b01:
                        begin
                            nxt.bank_low     = {1'b0, low7};
                            res.set_rom_bank = 1'b1;
                            res.rom_bank     = ROM_BANK_W'(low7);
                        end
                        2'b10:
                        begin
                            // RAM bank select up to 07h, RTC register select up to 0Ch, else ignored
                            if (wdata <= MBC3_BANK_MAX)
                            begin
                                nxt.bank_high = wdata[2:0];
                                res.xram_upd  = 1'b1;
                                res.xram_num  = {1'b0, wdata[2:0]};
                            end
                            else if (wdata <= MBC3_RTC_MAX)
                            begin
                                nxt.rtc_reg_sel = wdata[3:0];
                            end
                        end
                        default:
                        begin
                            // Arm on zero, fire on one while armed, any other value disarms
                            if (wdata == LATCH_FIRE && cur.latch_armed)
                            begin
                                nxt.latch_armed = 1'b0;
                                res.rtc_snap    = 1'b1;
                            end
                            else if (wdata == LATCH_ARM)
                            begin
                                nxt.latch_armed = 1'b1;
                            end
                            else
                            begin
                                nxt.latch_armed = 1'b0;
                            end
                        end
                    endcase
                    res.rtc_select = nxt.rtc_reg_sel;
                end
            end
            KIND_MBC5:
            begin
                if (!addr[15] && addr[14:13] != 2'b11)
                begin
                    res.handled = 1'b1;
                    unique case (addr[14:13])
                        2'b00:
                        begin
                            res.gate_upd    = 1'b1;
                            res.ram_gate_on = gate_on;
                        end
                        2'b01:
                        begin
                            res.set_rom_bank = 1'b1;
                            if (!addr[12])
                            begin
                                nxt.bank_low = wdata;
                                res.rom_bank = {cur.bank_high[0], wdata};
                            end
                            else
                            begin
                                nxt.bank_high = {2'b00, wdata[0]};
                                res.rom_bank  = {wdata[0], cur.bank_low};
                            end
                        end
                        default:
                        begin
                            nxt.xram_sel = wdata[3:0];
                            res.xram_upd = 1'b1;
                            res.xram_num = wdata[3:0];
                        end
                    endcase
                end
            end
            default:
            begin
                // No controller: ignore the write
                nxt = cur;
            end
        endcase
    end

endmodule
